// File: hdl/gsf_pkg.sv
package gsf_pkg;

    localparam int unsigned CAP_BITS = 13;
    localparam logic [CAP_BITS-1:0] CAP_RESET = 13'd4096;

    typedef enum logic [2:0] {
        F_WRITE = 3'd0,
        F_READ  = 3'd1,
        F_OPEN  = 3'd2,
        F_CLOSE = 3'd3,
        F_CLEAR = 3'd4
    } t_func;

    typedef struct packed {
        logic                popped;
        logic [31:0]         lost;
        logic [CAP_BITS-1:0] buffered;
        logic [31:0]         offered;
        logic [31:0]         delivered;
        logic [31:0]         dropped;
        logic [31:0]         overflow;
        logic                torn;
        logic                opened;
    } t_status;

    function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? '1 : s[31:0];
    endfunction

    function automatic logic [31:0] sat_inc32(input logic [31:0] a);
        return (a == '1) ? a : a + 32'd1;
    endfunction

endpackage

// File: hdl/gapless_sample_fifo_gap_report.sv
// A result appears in the cycle after its transfer, strobed by o_done for one cycle.
// Throughput: one item per cycle when not busy; the ring is a single-port-write,
// single-port-read memory whose registered read data lands in the cycle the result is
// shown. The receiver cannot stall; busy is high only during reset and the cycle after it.
// Reset (synchronous, active low) closes the stream, clears pointers and counters and sets
// the capacity register to 4096; ring contents are not cleared.
module gapless_sample_fifo_gap_report
    import gsf_pkg::*;
#(
    parameter int unsigned DEPTH       = 4096,
    parameter int unsigned SAMPLE_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [12:0]        i_cfg_wdata,
    input  logic               start,
    output logic               busy,
    input  logic [2:0]         i_func,
    input  logic signed [15:0] i_sample_i,
    input  logic signed [15:0] i_sample_q,
    output logic               o_done,
    output logic signed [15:0] o_out_i,
    output logic signed [15:0] o_out_q,
    output logic               o_out_valid,
    output logic [31:0]        o_lost_prior,
    output logic [12:0]        o_buffered,
    output logic [31:0]        o_offered_total,
    output logic [31:0]        o_delivered_total,
    output logic [31:0]        o_dropped_total,
    output logic [31:0]        o_overflow_total,
    output logic               o_is_torn,
    output logic               o_is_open
);

    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned MW = 2 * SAMPLE_BITS;

    logic          r_run;
    logic          accept;
    logic          we;
    logic          re;
    logic [AW-1:0] waddr;
    logic [AW-1:0] raddr;
    logic [MW-1:0] wdata;
    logic [MW-1:0] rdata;
    t_status       status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
        end else begin
            r_run <= 1'b1;
        end
    end

    assign busy   = ~r_run;
    assign accept = start & r_run;

    gsf_ctrl #(
        .DEPTH       (DEPTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_accept    (accept),
        .i_func      (i_func),
        .i_sample_i  (i_sample_i),
        .i_sample_q  (i_sample_q),
        .o_we        (we),
        .o_waddr     (waddr),
        .o_wdata     (wdata),
        .o_re        (re),
        .o_raddr     (raddr),
        .o_done      (o_done),
        .o_status    (status)
    );

    gsf_ring #(
        .DEPTH (DEPTH),
        .WIDTH (MW)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // zero the sample when no sample was popped (a read of an empty ring or any other function)
    assign o_out_i = status.popped ? 16'(rdata[SAMPLE_BITS-1:0]) : '0;
    assign o_out_q = status.popped ? 16'(rdata[MW-1:SAMPLE_BITS]) : '0;

    assign o_out_valid       = status.popped;
    assign o_lost_prior      = status.lost;
    assign o_buffered        = status.buffered;
    assign o_offered_total   = status.offered;
    assign o_delivered_total = status.delivered;
    assign o_dropped_total   = status.dropped;
    assign o_overflow_total  = status.overflow;
    assign o_is_torn         = status.torn;
    assign o_is_open         = status.opened;

endmodule

// File: hdl/gsf_ring.sv
module gsf_ring
    import gsf_pkg::*;
#(
    parameter int unsigned DEPTH = 4096,
    parameter int unsigned WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/gsf_ctrl.sv
module gsf_ctrl
    import gsf_pkg::*;
#(
    parameter int unsigned DEPTH       = 4096,
    parameter int unsigned SAMPLE_BITS = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [CAP_BITS-1:0]        i_cfg_wdata,
    input  logic                       i_accept,
    input  logic [2:0]                 i_func,
    input  logic [15:0]                i_sample_i,
    input  logic [15:0]                i_sample_q,
    output logic                       o_we,
    output logic [$clog2(DEPTH)-1:0]   o_waddr,
    output logic [2*SAMPLE_BITS-1:0]   o_wdata,
    output logic                       o_re,
    output logic [$clog2(DEPTH)-1:0]   o_raddr,
    output logic                       o_done,
    output t_status                    o_status
);

    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);

    logic [CAP_BITS-1:0] r_capacity;
    logic [CW-1:0]       r_cap,    n_cap;
    logic [AW-1:0]       r_head,   n_head;
    logic [AW-1:0]       r_tail,   n_tail;
    logic [CW-1:0]       r_fill,   n_fill;
    logic                r_torn,   n_torn;
    logic                r_open,   n_open;
    logic [31:0]         r_hole,   n_hole;
    logic [31:0]         r_gap,    n_gap;
    logic [31:0]         r_offer,  n_offer;
    logic [31:0]         r_deliv,  n_deliv;
    logic [31:0]         r_drop,   n_drop;
    logic [31:0]         r_ovf,    n_ovf;
    logic                r_done;
    t_status             r_status;
    logic                popped;
    logic [31:0]         lost;
    logic [CW-1:0]       cap_clamp;

    function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] p,
                                                 input logic [CW-1:0] cap);
        logic [CW:0] p1;
        p1 = (CW + 1)'(p) + (CW + 1)'(1);
        return (p1 >= (CW + 1)'(cap)) ? '0 : AW'(p1);
    endfunction

    assign cap_clamp = (32'(r_capacity) > 32'(DEPTH)) ? CW'(DEPTH) : CW'(r_capacity);

    always_comb begin
        n_cap   = r_cap;
        n_head  = r_head;
        n_tail  = r_tail;
        n_fill  = r_fill;
        n_torn  = r_torn;
        n_open  = r_open;
        n_hole  = r_hole;
        n_gap   = r_gap;
        n_offer = r_offer;
        n_deliv = r_deliv;
        n_drop  = r_drop;
        n_ovf   = r_ovf;
        popped  = 1'b0;
        lost    = '0;
        o_we    = 1'b0;
        o_re    = 1'b0;
        case (i_func)
            F_WRITE: begin
                if (r_open) begin
                    n_offer = sat_inc32(r_offer);
                    if (r_torn) begin
                        n_hole = sat_inc32(r_hole);
                        n_drop = sat_inc32(r_drop);
                    end else begin
                        n_gap  = sat_add32(r_gap, r_hole);
                        n_hole = '0;
                        if (r_fill < r_cap) begin
                            o_we   = i_accept;
                            n_head = next_slot(r_head, r_cap);
                            n_fill = r_fill + CW'(1);
                        end else begin
                            n_drop = sat_inc32(r_drop);
                            n_ovf  = sat_inc32(r_ovf);
                            n_hole = 32'd1;
                            n_torn = 1'b1;
                        end
                    end
                end
            end
            F_READ: begin
                lost  = r_gap;
                n_gap = '0;
                if (r_fill != '0) begin
                    popped  = 1'b1;
                    o_re    = i_accept;
                    n_tail  = next_slot(r_tail, r_cap);
                    n_fill  = r_fill - CW'(1);
                    n_deliv = sat_inc32(r_deliv);
                end
                if (n_fill == '0) begin
                    n_torn = 1'b0;
                end
            end
            F_OPEN: begin
                if (r_capacity != '0) begin
                    n_cap  = cap_clamp;
                    n_drop = sat_add32(r_drop, 32'(r_fill));
                    n_gap  = sat_add32(sat_add32(r_gap, 32'(r_fill)), r_hole);
                    n_head = '0;
                    n_tail = '0;
                    n_fill = '0;
                    n_torn = 1'b0;
                    n_hole = '0;
                    n_open = 1'b1;
                end
            end
            F_CLOSE: begin
                n_cap  = '0;
                n_drop = sat_add32(r_drop, 32'(r_fill));
                n_gap  = '0;
                n_head = '0;
                n_tail = '0;
                n_fill = '0;
                n_torn = 1'b0;
                n_hole = '0;
                n_open = 1'b0;
            end
            F_CLEAR: begin
                n_offer = '0;
                n_deliv = '0;
                n_drop  = '0;
                n_ovf   = '0;
            end
            default: begin
            end
        endcase
    end

    assign o_waddr = r_head;
    assign o_raddr = r_tail;
    assign o_wdata = {SAMPLE_BITS'($unsigned(i_sample_q)),
                      SAMPLE_BITS'($unsigned(i_sample_i))};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAP_RESET;
        end else if (i_cfg_we) begin
            r_capacity <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap   <= '0;
            r_head  <= '0;
            r_tail  <= '0;
            r_fill  <= '0;
            r_torn  <= 1'b0;
            r_open  <= 1'b0;
            r_hole  <= '0;
            r_gap   <= '0;
            r_offer <= '0;
            r_deliv <= '0;
            r_drop  <= '0;
            r_ovf   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= i_accept;
            if (i_accept) begin
                r_cap   <= n_cap;
                r_head  <= n_head;
                r_tail  <= n_tail;
                r_fill  <= n_fill;
                r_torn  <= n_torn;
                r_open  <= n_open;
                r_hole  <= n_hole;
                r_gap   <= n_gap;
                r_offer <= n_offer;
                r_deliv <= n_deliv;
                r_drop  <= n_drop;
                r_ovf   <= n_ovf;
            end
        end
    end

    // capture the result status alongside the state update
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_status.popped    <= popped;
            r_status.lost      <= lost;
            r_status.buffered  <= CAP_BITS'(n_fill);
            r_status.offered   <= n_offer;
            r_status.delivered <= n_deliv;
            r_status.dropped   <= n_drop;
            r_status.overflow  <= n_ovf;
            r_status.torn      <= n_torn;
            r_status.opened    <= n_open;
        end
    end

    assign o_done   = r_done;
    assign o_status = r_status;

endmodule

// File: hdl/gsf_checker.sv
module gsf_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_done,
    input logic [15:0] o_out_i,
    input logic [15:0] o_out_q,
    input logic        o_out_valid,
    input logic [12:0] o_buffered,
    input logic        o_is_torn,
    input logic        o_is_open
);

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> o_done)
        else $error("transfer not followed by a result strobe");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start && !busy))
        else $error("result strobe without a transfer");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_out_valid) |-> (o_out_i == 16'd0 && o_out_q == 16'd0))
        else $error("sample data on a result without a popped sample");

    a_torn_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_is_torn) |-> o_is_open)
        else $error("torn while closed");

    a_closed_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_is_open) |-> (o_buffered == 13'd0))
        else $error("samples held while closed");

endmodule

bind gapless_sample_fifo_gap_report gsf_checker u_gsf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .o_done      (o_done),
    .o_out_i     (o_out_i),
    .o_out_q     (o_out_q),
    .o_out_valid (o_out_valid),
    .o_buffered  (o_buffered),
    .o_is_torn   (o_is_torn),
    .o_is_open   (o_is_open)
);
